/* design/esi_pkg.sv */
// Shared types and constants for the encoder position stall injector.
// No dependencies; every other file in the design uses this package.
package esi_pkg;

  localparam int CMD_W   = 2;
  localparam int POS_W   = 32;
  localparam int MODE_W  = 2;
  localparam int QCNT_W  = 4;
  localparam int RCNT_W  = 2;
  localparam int RQ_DEPTH = 3;

  // Commands
  localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FEED_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FEED_END   = 2'd2;

  // Stall modes
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd2;

  typedef struct packed {
    logic signed [POS_W-1:0] threshold;
    logic                    forward;
    logic [RCNT_W-1:0]       count;
  } rule_t;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [POS_W-1:0] position;
  } item_t;

  typedef struct packed {
    logic              stop_motor;
    logic              rule_armed;
    logic [QCNT_W-1:0] queued_rules;
  } result_t;

endpackage

/* design/esi_if.sv */
// Request channel interfaces: input items and result items.
// Depends on esi_pkg for field widths.
interface esi_in_if;
  logic                             valid;
  logic                             ready;
  logic [esi_pkg::CMD_W-1:0]        command;
  logic signed [esi_pkg::POS_W-1:0] position;

  modport source(output valid, command, position, input ready);
  modport sink(input valid, command, position, output ready);
endinterface

interface esi_out_if;
  logic                       valid;
  logic                       ready;
  logic                       stop_motor;
  logic                       rule_armed;
  logic [esi_pkg::QCNT_W-1:0] queued_rules;

  modport source(output valid, stop_motor, rule_armed, queued_rules, input ready);
  modport sink(input valid, stop_motor, rule_armed, queued_rules, output ready);
endinterface

/* design/esi_rule_engine.sv */
// Rule FIFO, armed rule and last position, updated once per request.
// Depends on esi_pkg.
module esi_rule_engine #(
  parameter int FIFO_DEPTH    = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  input  esi_pkg::item_t               item,
  input  logic [esi_pkg::MODE_W-1:0]   stall_mode,
  output esi_pkg::result_t             result
);

  localparam int HW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam logic signed [31:0] TURN_ONE = 32'(64'd1 << FRACTION_BITS);
  localparam logic signed [31:0] TURN_095 =
    32'(((64'd95 << FRACTION_BITS) + 64'd50) / 64'd100);
  localparam logic signed [31:0] TURN_097 =
    32'(((64'd97 << FRACTION_BITS) + 64'd50) / 64'd100);

  esi_pkg::rule_t fifo_r [FIFO_DEPTH];
  esi_pkg::rule_t wr_data [FIFO_DEPTH];
  logic [FIFO_DEPTH-1:0] wr_en;

  logic [CW-1:0] cnt_r, cnt_nxt, cnt_pop;
  logic [HW-1:0] head_r, head_nxt, head_pop, slot;
  logic [SW-1:0] slot_sum;
  logic          armed_r, armed_nxt;
  logic signed [esi_pkg::POS_W-1:0] thr_r, thr_nxt, last_r, last_nxt;
  logic          fwd_r, fwd_nxt;
  logic [esi_pkg::RCNT_W-1:0] acnt_r, acnt_nxt;
  logic          pop, drop, moving, reach, fire;
  esi_pkg::rule_t head_rule;

  assign head_rule = fifo_r[head_r];

  always_comb begin
    cnt_nxt   = cnt_r;
    head_nxt  = head_r;
    armed_nxt = armed_r;
    thr_nxt   = thr_r;
    fwd_nxt   = fwd_r;
    acnt_nxt  = acnt_r;
    last_nxt  = last_r;
    fire      = 1'b0;
    pop       = 1'b0;
    drop      = 1'b0;
    moving    = 1'b0;
    reach     = 1'b0;
    head_pop  = head_r;
    cnt_pop   = cnt_r;
    slot_sum  = '0;
    slot      = '0;
    wr_en     = '0;
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      wr_data[i] = '0;
    end

    if (item_valid) begin
      unique case (item.command)
        esi_pkg::CMD_TICK: begin
          last_nxt = item.position;
          pop = !armed_r && (cnt_r != '0);
          if (pop) begin
            head_pop = (head_r == HW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
            cnt_pop  = cnt_r - 1'b1;
          end
          head_nxt = head_pop;
          cnt_nxt  = cnt_pop;
          drop = pop && (head_rule.count == '0);
          if (pop && !drop) begin
            armed_nxt = 1'b1;
            thr_nxt   = head_rule.threshold;
            fwd_nxt   = head_rule.forward;
            acnt_nxt  = head_rule.count;
          end
          moving = fwd_nxt ? (item.position > last_r) : (item.position < last_r);
          reach  = fwd_nxt ? (item.position >= thr_nxt) : (item.position <= thr_nxt);
          fire   = armed_nxt && !drop && moving && reach;
          if (fire) begin
            armed_nxt = 1'b0;
            acnt_nxt  = acnt_nxt - 1'b1;
            // re-queue at the tail while the rule has firings left and the fifo has room
            if (acnt_nxt != '0 && cnt_pop < CW'(FIFO_DEPTH)) begin
              slot_sum = SW'(head_pop) + SW'(cnt_pop);
              slot = (slot_sum >= SW'(FIFO_DEPTH)) ? HW'(slot_sum - SW'(FIFO_DEPTH))
                                                    : HW'(slot_sum);
              wr_en[slot]   = 1'b1;
              wr_data[slot] = '{threshold: thr_nxt, forward: fwd_nxt, count: acnt_nxt};
              cnt_nxt       = cnt_pop + 1'b1;
            end
          end
        end
        esi_pkg::CMD_FEED_START: begin
          armed_nxt = 1'b0;
          head_nxt  = '0;
          cnt_nxt   = '0;
          if (stall_mode == esi_pkg::MODE_SINGLE || stall_mode == esi_pkg::MODE_DOUBLE) begin
            wr_en[0]   = 1'b1;
            wr_data[0] = '{threshold: TURN_ONE, forward: 1'b1, count: 2'd1};
            cnt_nxt    = CW'(1);
          end
          if (stall_mode == esi_pkg::MODE_DOUBLE) begin
            wr_en[1]   = 1'b1;
            wr_data[1] = '{threshold: TURN_095, forward: 1'b0, count: 2'd3};
            wr_en[2]   = 1'b1;
            wr_data[2] = '{threshold: TURN_097, forward: 1'b1, count: 2'd3};
            cnt_nxt    = CW'(3);
          end
        end
        esi_pkg::CMD_FEED_END: begin
          head_nxt = '0;
          cnt_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign result.stop_motor   = fire;
  assign result.rule_armed   = armed_nxt;
  assign result.queued_rules = esi_pkg::QCNT_W'(cnt_nxt);

  always_ff @(posedge clk) begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if (wr_en[i]) begin
        fifo_r[i] <= wr_data[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      head_r  <= '0;
      armed_r <= 1'b0;
      thr_r   <= '0;
      fwd_r   <= 1'b0;
      acnt_r  <= '0;
      last_r  <= '0;
    end else begin
      cnt_r   <= cnt_nxt;
      head_r  <= head_nxt;
      armed_r <= armed_nxt;
      thr_r   <= thr_nxt;
      fwd_r   <= fwd_nxt;
      acnt_r  <= acnt_nxt;
      last_r  <= last_nxt;
    end
  end

  a_fire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && fire |=> !armed_r)
    else $error("armed rule still armed after firing");

  a_feed_start_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item.command == esi_pkg::CMD_FEED_START |=> !armed_r && head_r == '0)
    else $error("feed start left a rule armed");

  a_feed_end_empties: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item.command == esi_pkg::CMD_FEED_END && !armed_r
    |=> cnt_r == '0 && !armed_r)
    else $error("feed end left rules queued");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(FIFO_DEPTH) && head_r <= HW'(FIFO_DEPTH - 1))
    else $error("fifo count or head out of range");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !item_valid |=> $stable(cnt_r) && $stable(armed_r) && $stable(last_r))
    else $error("state changed without a request");

endmodule

/* design/esi_out_queue.sv */
// Three-entry result queue driving the result channel.
// Depends on esi_pkg and esi_out_if.
module esi_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  esi_pkg::result_t  push_data,
  output logic [1:0]        level,
  esi_out_if.source         out_ch
);

  localparam logic [1:0] LAST_IDX = 2'(esi_pkg::RQ_DEPTH - 1);

  esi_pkg::result_t q_r [esi_pkg::RQ_DEPTH];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt, cnt_r, cnt_nxt;
  logic       pop;

  assign pop   = out_ch.valid && out_ch.ready;
  assign level = cnt_r;

  assign out_ch.valid        = (cnt_r != 2'd0);
  assign out_ch.stop_motor   = q_r[rd_r].stop_motor;
  assign out_ch.rule_armed   = q_r[rd_r].rule_armed;
  assign out_ch.queued_rules = q_r[rd_r].queued_rules;

  always_comb begin
    wr_nxt  = push ? ((wr_r == LAST_IDX) ? 2'd0 : wr_r + 2'd1) : wr_r;
    rd_nxt  = pop  ? ((rd_r == LAST_IDX) ? 2'd0 : rd_r + 2'd1) : rd_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> cnt_r < 2'(esi_pkg::RQ_DEPTH))
    else $error("result queue overflow");

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(esi_pkg::RQ_DEPTH))
    else $error("result queue level out of range");

  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> wr_r == rd_r)
    else $error("empty queue with pointers apart");

endmodule

/* design/encoder_position_stall_injector.sv */
// Encoder position stall injector: top level with input register and config.
// Depends on esi_pkg, esi_if, esi_rule_engine and esi_out_queue.
//
// Usage:
//   in_ch carries requests {command, position}: tick with position, feed
//   start or feed end. out_ch returns one result per request:
//   {stop_motor, rule_armed, queued_rules}, in request order.
//   cfg_we/cfg_wdata write stall_mode; write it only while no request is
//   in flight. It picks the rule set loaded on feed start.
// Timing:
//   A request is registered on acceptance, its rule update is done in the
//   following cycle and the result enters a three-entry result queue.
//   One request per cycle is taken while out_ch keeps up; the figure is set
//   by the combinational rule update and the result queue depth.
// Reset (rst_n low, synchronous): no rule armed, FIFO empty, last position
//   zero, stall_mode none, result queue empty.
// Stall: while out_ch.ready is low the queue fills; in_ch.ready drops once
//   the queue plus the input register hold three results.
module encoder_position_stall_injector #(
  parameter int FIFO_DEPTH    = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  esi_in_if.sink                      in_ch,
  esi_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [esi_pkg::MODE_W-1:0]  cfg_wdata
);

  logic [esi_pkg::MODE_W-1:0] mode_r;
  logic                       s1_valid_r;
  esi_pkg::item_t             s1_item_r;
  esi_pkg::result_t           result;
  logic [1:0]                 q_level;
  logic [2:0]                 in_flight;
  logic                       accept;

  // hold off once the queue could not absorb everything in flight
  assign in_flight   = {1'b0, q_level} + {2'b0, s1_valid_r};
  assign in_ch.ready = (in_flight < 3'(esi_pkg::RQ_DEPTH));
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= esi_pkg::MODE_NONE;
      s1_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        mode_r <= cfg_wdata;
      end
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r.command  <= in_ch.command;
      s1_item_r.position <= in_ch.position;
    end
  end

  esi_rule_engine #(
    .FIFO_DEPTH    (FIFO_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_valid_r),
    .item       (s1_item_r),
    .stall_mode (mode_r),
    .result     (result)
  );

  esi_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_valid_r),
    .push_data (result),
    .level     (q_level),
    .out_ch    (out_ch)
  );

endmodule

/* sim/esi_stall_checker.sv */
// Result checker for the encoder position stall injector: watches the request,
// result and config ports, predicts each status and compares it in order.
// Depends on esi_pkg for commands, modes and the rule and result layouts.
module esi_stall_checker #(
  parameter int FIFO_DEPTH    = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic [esi_pkg::CMD_W-1:0]        in_command,
  input  logic signed [esi_pkg::POS_W-1:0] in_position,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic                             out_stop_motor,
  input  logic                             out_rule_armed,
  input  logic [esi_pkg::QCNT_W-1:0]       out_queued_rules,
  input  logic                             cfg_we,
  input  logic [esi_pkg::MODE_W-1:0]       cfg_wdata,
  output int                               fail_count,
  output int                               pending
);

  // Built-in thresholds, rounded to nearest at FRACTION_BITS
  localparam longint unsigned ONE_RAW = 64'd1 << FRACTION_BITS;
  localparam logic signed [esi_pkg::POS_W-1:0] TURN_ONE = esi_pkg::POS_W'(ONE_RAW);
  localparam logic signed [esi_pkg::POS_W-1:0] TURN_095 =
    esi_pkg::POS_W'(((64'd95 << FRACTION_BITS) + 64'd50) / 64'd100);
  localparam logic signed [esi_pkg::POS_W-1:0] TURN_097 =
    esi_pkg::POS_W'(((64'd97 << FRACTION_BITS) + 64'd50) / 64'd100);

  esi_pkg::rule_t                   rule_store [FIFO_DEPTH];
  int unsigned                      rules_waiting;
  int unsigned                      rule_head;
  logic                             rule_live;
  logic signed [esi_pkg::POS_W-1:0] live_threshold;
  logic                             live_forward;
  logic [esi_pkg::RCNT_W-1:0]       live_count;
  logic signed [esi_pkg::POS_W-1:0] prev_position;
  logic [esi_pkg::MODE_W-1:0]       stall_mode_q;
  esi_pkg::result_t                 expected_status_q [$];

  function automatic void queue_rule(input logic signed [esi_pkg::POS_W-1:0] thr,
                                     input logic fwd,
                                     input logic [esi_pkg::RCNT_W-1:0] cnt);
    int unsigned slot;
    if (rules_waiting >= FIFO_DEPTH) return;  // drop push into a full fifo
    slot = (rule_head + rules_waiting) % FIFO_DEPTH;
    rule_store[slot] = '{threshold: thr, forward: fwd, count: cnt};
    rules_waiting++;
  endfunction

  function automatic esi_pkg::result_t predict_status(
      input logic [esi_pkg::CMD_W-1:0] cmd,
      input logic signed [esi_pkg::POS_W-1:0] pos);
    esi_pkg::rule_t   head_rule;
    logic             fired;
    logic             moving;
    logic             reached;
    esi_pkg::result_t status;
    fired = 1'b0;
    case (cmd)
      esi_pkg::CMD_TICK: begin
        if (!rule_live && rules_waiting > 0) begin
          head_rule = rule_store[rule_head];
          rule_head = (rule_head + 1) % FIFO_DEPTH;
          rules_waiting--;
          // a zero-count rule is dropped without arming
          if (head_rule.count != '0) begin
            live_threshold = head_rule.threshold;
            live_forward   = head_rule.forward;
            live_count     = head_rule.count;
            rule_live      = 1'b1;
          end
        end
        if (rule_live) begin
          moving  = live_forward ? (pos > prev_position) : (pos < prev_position);
          reached = live_forward ? (pos >= live_threshold) : (pos <= live_threshold);
          if (moving && reached) begin
            rule_live  = 1'b0;
            live_count = live_count - 1'b1;
            fired      = 1'b1;
            if (live_count != '0) queue_rule(live_threshold, live_forward, live_count);
          end
        end
        prev_position = pos;
      end
      esi_pkg::CMD_FEED_START: begin
        rule_live     = 1'b0;
        rules_waiting = 0;
        rule_head     = 0;
        if (stall_mode_q == esi_pkg::MODE_SINGLE || stall_mode_q == esi_pkg::MODE_DOUBLE)
          queue_rule(TURN_ONE, 1'b1, esi_pkg::RCNT_W'(1));
        if (stall_mode_q == esi_pkg::MODE_DOUBLE) begin
          queue_rule(TURN_095, 1'b0, esi_pkg::RCNT_W'(3));
          queue_rule(TURN_097, 1'b1, esi_pkg::RCNT_W'(3));
        end
      end
      esi_pkg::CMD_FEED_END: begin
        rules_waiting = 0;
        rule_head     = 0;
      end
      default: ;
    endcase
    status.stop_motor   = fired;
    status.rule_armed   = rule_live;
    status.queued_rules = esi_pkg::QCNT_W'(rules_waiting);
    return status;
  endfunction

  always @(posedge clk) begin
    esi_pkg::result_t want;
    if (!rst_n) begin
      rules_waiting  = 0;
      rule_head      = 0;
      rule_live      = 1'b0;
      live_threshold = '0;
      live_forward   = 1'b0;
      live_count     = '0;
      prev_position  = '0;
      stall_mode_q   = esi_pkg::MODE_NONE;
      fail_count     = 0;
      expected_status_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_status_q.size() == 0) begin
          $error("result with no request waiting: stop_motor %0d rule_armed %0d queued_rules %0d",
                 out_stop_motor, out_rule_armed, out_queued_rules);
          fail_count++;
        end else begin
          want = expected_status_q.pop_front();
          if (out_stop_motor !== want.stop_motor) begin
            $error("stop_motor: expected %0d, got %0d", want.stop_motor, out_stop_motor);
            fail_count++;
          end
          if (out_rule_armed !== want.rule_armed) begin
            $error("rule_armed: expected %0d, got %0d", want.rule_armed, out_rule_armed);
            fail_count++;
          end
          if (out_queued_rules !== want.queued_rules) begin
            $error("queued_rules: expected %0d, got %0d", want.queued_rules, out_queued_rules);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        expected_status_q.push_back(predict_status(in_command, in_position));
      if (cfg_we) stall_mode_q = cfg_wdata;
    end
    pending = expected_status_q.size();
  end

endmodule

/* sim/encoder_position_stall_injector_tb.sv */
// Testbench top for the encoder position stall injector: clock, reset, request
// stimulus, result-side stalls and the verdict. Depends on esi_pkg, esi_if,
// the block itself and esi_stall_checker.
module encoder_position_stall_injector_tb;

  localparam int LIMIT_CYCLES = 200000;
  localparam int RANDOM_REQUESTS = 450;
  localparam logic [esi_pkg::CMD_W-1:0]  CMD_UNUSED    = 2'd3;
  localparam logic [esi_pkg::MODE_W-1:0] MODE_RESERVED = 2'd3;
  localparam logic signed [esi_pkg::POS_W-1:0] TURN_ONE = 32'sd65536;
  localparam logic signed [esi_pkg::POS_W-1:0] TURN_095 = 32'sd62259;
  localparam logic signed [esi_pkg::POS_W-1:0] TURN_097 = 32'sd63570;

  typedef enum int {DRAIN_FREE, DRAIN_JITTER, DRAIN_THROTTLED} drain_style_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             cfg_we;
  logic [esi_pkg::MODE_W-1:0]       cfg_wdata;
  int                               fail_count;
  int                               pending;
  int                               burst_left;
  int                               sent_count;
  int                               cycle_count = 0;
  logic signed [esi_pkg::POS_W-1:0] shaft_pos;
  int                               shaft_dir;

  esi_in_if  in_ch ();
  esi_out_if out_ch ();

  always #4 clk = ~clk;

  encoder_position_stall_injector dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  esi_stall_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_command      (in_ch.command),
    .in_position     (in_ch.position),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_stop_motor  (out_ch.stop_motor),
    .out_rule_armed  (out_ch.rule_armed),
    .out_queued_rules(out_ch.queued_rules),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Present one request and hold it until accepted; returns at a falling edge.
  task automatic send_request(input logic [esi_pkg::CMD_W-1:0] cmd,
                              input logic signed [esi_pkg::POS_W-1:0] pos);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
    end
    in_ch.valid    <= 1'b1;
    in_ch.command  <= cmd;
    in_ch.position <= pos;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    burst_left--;
    sent_count++;
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_stall_mode(input logic [esi_pkg::MODE_W-1:0] mode);
    pause_until_drained();
    repeat (3) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Oscillate the shaft around the built-in thresholds so rules keep firing.
  task automatic send_motion_ticks(input int n);
    int step;
    for (int i = 0; i < n; i++) begin
      if (shaft_pos > 32'sd72000) shaft_dir = -1;
      else if (shaft_pos < 32'sd56000) shaft_dir = 1;
      else if ($urandom_range(0, 5) == 0) shaft_dir = -shaft_dir;
      step = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 20000) : $urandom_range(0, 3000);
      shaft_pos = shaft_pos + shaft_dir * step;
      send_request(esi_pkg::CMD_TICK, shaft_pos);
    end
  endtask

  // Result-side stalls: free flow, random jitter and long throttled stretches.
  initial begin
    drain_style_t style;
    int           left;
    out_ch.ready = 1'b0;
    style = DRAIN_FREE;
    left  = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = drain_style_t'($urandom_range(0, 2));
        left  = $urandom_range(20, 80);
      end
      left--;
      case (style)
        DRAIN_FREE:   out_ch.ready <= 1'b1;
        DRAIN_JITTER: out_ch.ready <= ($urandom_range(0, 1) == 1);
        default:      out_ch.ready <= ((left % 8) == 0);
      endcase
    end
  end

  initial begin
    int roll;
    in_ch.valid    = 1'b0;
    in_ch.command  = esi_pkg::CMD_TICK;
    in_ch.position = '0;
    cfg_we         = 1'b0;
    cfg_wdata      = esi_pkg::MODE_NONE;
    rst_n          = 1'b0;
    burst_left     = 0;
    sent_count     = 0;
    shaft_pos      = '0;
    shaft_dir      = 1;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single rule: approach, exact threshold, overshoot with nothing armed
    write_stall_mode(esi_pkg::MODE_SINGLE);
    send_request(esi_pkg::CMD_FEED_START, 32'sh1234_5678);
    send_request(esi_pkg::CMD_TICK, 32'sd0);
    send_request(esi_pkg::CMD_TICK, TURN_ONE - 1);
    send_request(esi_pkg::CMD_TICK, TURN_ONE);
    send_request(esi_pkg::CMD_TICK, 32'sd70000);
    send_request(esi_pkg::CMD_FEED_END, '0);

    // double set: armed rule survives feed end, then every rule at its edge
    write_stall_mode(esi_pkg::MODE_DOUBLE);
    send_request(esi_pkg::CMD_FEED_START, '0);
    send_request(esi_pkg::CMD_TICK, 32'sd0);
    send_request(esi_pkg::CMD_FEED_END, 32'shFFFF_FFFF);
    send_request(esi_pkg::CMD_TICK, TURN_ONE);
    send_request(esi_pkg::CMD_FEED_START, '0);
    send_request(esi_pkg::CMD_TICK, 32'sh7FFF_FFFF);
    send_request(esi_pkg::CMD_TICK, TURN_095);
    send_request(esi_pkg::CMD_TICK, TURN_097);
    send_request(esi_pkg::CMD_TICK, TURN_097);
    send_request(esi_pkg::CMD_FEED_END, '0);
    send_request(esi_pkg::CMD_TICK, 32'sh8000_0000);
    send_request(esi_pkg::CMD_TICK, -32'sd1);
    send_request(esi_pkg::CMD_TICK, -32'sd1);
    send_request(CMD_UNUSED, 32'sh5555_AAAA);

    // reserved and empty modes load nothing
    write_stall_mode(MODE_RESERVED);
    send_request(esi_pkg::CMD_FEED_START, '0);
    send_request(esi_pkg::CMD_TICK, 32'sd0);
    write_stall_mode(esi_pkg::MODE_NONE);
    send_request(esi_pkg::CMD_FEED_START, '0);
    send_request(esi_pkg::CMD_TICK, 32'sd1);

    // mostly feed cycles with oscillating motion, some raw noise
    write_stall_mode(esi_pkg::MODE_DOUBLE);
    sent_count = 0;
    while (sent_count < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 3) == 0)
        write_stall_mode(esi_pkg::MODE_W'($urandom_range(0, 2)));
      roll = $urandom_range(0, 9);
      if (roll < 8) begin
        shaft_pos = $urandom_range(45000, 64000);
        shaft_dir = 1;
        send_request(esi_pkg::CMD_FEED_START, $urandom());
        send_motion_ticks($urandom_range(8, 40));
        if ($urandom_range(0, 2) == 0) send_request(esi_pkg::CMD_FEED_END, $urandom());
        send_motion_ticks($urandom_range(0, 10));
      end else begin
        repeat ($urandom_range(3, 12))
          send_request(esi_pkg::CMD_W'($urandom_range(0, 2)), $urandom());
      end
      if ($urandom_range(0, 7) == 0) pause_until_drained();
    end

    pause_until_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
